// ----- rtl/cptl_pkg.sv -----
// ----------------------------------------------------------------------------
// cptl_pkg
// Shared types, codes and character helpers for the preprocessing token lexer.
// ----------------------------------------------------------------------------
package cptl_pkg;

  // Width of the internal line counter; it saturates at its all-ones value.
  localparam int LINE_BITS  = 32;
  // Width of the line number field on the result channel.
  localparam int LINE_OUT_W = 32;

  typedef logic [LINE_BITS-1:0] line_cnt_t;
  typedef logic [7:0]           char_t;
  typedef logic [2:0]           kind_t;

  localparam kind_t KIND_NL    = 3'd0;
  localparam kind_t KIND_WS    = 3'd1;
  localparam kind_t KIND_IDENT = 3'd2;
  localparam kind_t KIND_NUM   = 3'd3;
  localparam kind_t KIND_STR   = 3'd4;
  localparam kind_t KIND_CHR   = 3'd5;
  localparam kind_t KIND_PUNCT = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WS,
    MODE_IDENT,
    MODE_NUM,
    MODE_STR,
    MODE_CHR
  } mode_t;

  localparam char_t CH_NL     = 8'h0A;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_HASH   = 8'h23;
  localparam char_t CH_UNDER  = 8'h5F;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_VT     = 8'h0B;

  // Lexer state carried from one byte to the next.
  typedef struct packed {
    mode_t mode;
    logic  esc;
    logic  hash;
  } lex_state_t;

  // Per-byte classification handed back to the top level.
  typedef struct packed {
    kind_t kind;
    logic  start;
    logic  line_inc;
  } lex_res_t;

  // One result item as held in the output stages.
  typedef struct packed {
    logic [LINE_OUT_W-1:0] line;
    logic                  start;
    kind_t                 kind;
    char_t                 ch;
  } out_item_t;

  function automatic logic is_blank(input char_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha_us(input char_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_UNDER);
  endfunction

endpackage

// ----- rtl/cptl_classify.sv -----
// ----------------------------------------------------------------------------
// cptl_classify
// Decides the token class of one byte and the lexer state that follows it.
// ----------------------------------------------------------------------------
module cptl_classify
  import cptl_pkg::*;
(
  input  char_t      ch,
  input  lex_state_t st,
  output lex_res_t   res,
  output lex_state_t st_nxt
);

  logic cont;

  always_comb begin
    res        = '{kind: KIND_PUNCT, start: 1'b0, line_inc: 1'b0};
    st_nxt     = st;
    st_nxt.hash = 1'b0;
    cont       = 1'b1;

    // Continuation of a token that is already open.
    if (st.mode == MODE_STR || st.mode == MODE_CHR) begin
      res.kind = (st.mode == MODE_STR) ? KIND_STR : KIND_CHR;
      if (st.esc) begin
        st_nxt.esc = 1'b0;
      end else if (ch == CH_BSLASH) begin
        st_nxt.esc = 1'b1;
      end else if ((st.mode == MODE_STR && ch == CH_DQUOTE) ||
                   (st.mode == MODE_CHR && ch == CH_SQUOTE)) begin
        st_nxt.mode = MODE_IDLE;
      end
    end else if (st.mode == MODE_WS && is_blank(ch)) begin
      res.kind = KIND_WS;
    end else if (st.mode == MODE_IDENT && (is_alpha_us(ch) || is_digit(ch))) begin
      res.kind = KIND_IDENT;
    end else if (st.mode == MODE_NUM && is_digit(ch)) begin
      res.kind = KIND_NUM;
    end else if (st.hash && ch == CH_HASH) begin
      // Second hash of a "##" pair closes the token.
      res.kind    = KIND_PUNCT;
      st_nxt.mode = MODE_IDLE;
    end else begin
      cont = 1'b0;
    end

    if (!cont) begin
      res.start  = 1'b1;
      st_nxt.esc = 1'b0;
      if (ch == CH_NL) begin
        res.kind     = KIND_NL;
        res.line_inc = 1'b1;
        st_nxt.mode  = MODE_IDLE;
      end else if (is_blank(ch)) begin
        res.kind    = KIND_WS;
        st_nxt.mode = MODE_WS;
      end else if (is_alpha_us(ch)) begin
        res.kind    = KIND_IDENT;
        st_nxt.mode = MODE_IDENT;
      end else if (is_digit(ch)) begin
        res.kind    = KIND_NUM;
        st_nxt.mode = MODE_NUM;
      end else if (ch == CH_DQUOTE) begin
        res.kind    = KIND_STR;
        st_nxt.mode = MODE_STR;
      end else if (ch == CH_SQUOTE) begin
        res.kind    = KIND_CHR;
        st_nxt.mode = MODE_CHR;
      end else begin
        res.kind    = KIND_PUNCT;
        st_nxt.mode = MODE_IDLE;
        st_nxt.hash = (ch == CH_HASH);
      end
    end
  end

endmodule

// ----- rtl/c_preprocessor_token_lexer.sv -----
// ----------------------------------------------------------------------------
// c_preprocessor_token_lexer
// Splits a byte stream of C source into preprocessing tokens, one result per
// byte, tagged with token class, start flag and starting line number.
//
//   channel  dir  tdata                            tuser
//   in_      in   [7:0] text_byte                  -
//   out_     out  [7:0] char_out,                  [2:0] token_kind,
//                 [39:8] line_number               [3] token_start
//
// One byte is accepted per clock while in_tready is high. Classification and
// the state update are one level of logic ahead of the output register, so
// the lexer state loop sets the one-byte-per-cycle rate. A two-entry output
// stage (result register, plus skid register on an output stall) keeps input
// acceptance going while a result waits; in_tready falls only when both hold.
// rst_n is synchronous and active low; the line counter restarts at one.
// ----------------------------------------------------------------------------
module c_preprocessor_token_lexer
  import cptl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] char_out, [39:8] line_number
  output logic [3:0]  out_tuser   // [2:0] token_kind, [3] token_start
);

  localparam line_cnt_t LINE_MAX = '1;

  lex_state_t st_r, st_nxt;
  line_cnt_t  line_cnt_r, line_cnt_nxt;
  lex_res_t   res;
  out_item_t  item;
  out_item_t  out_r, skid_r;
  logic       out_v_r, skid_v_r;
  logic       accept;
  logic [63:0] line_ext;

  cptl_classify u_classify (
    .ch     (in_tdata),
    .st     (st_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  assign in_tready = !skid_v_r;
  assign accept    = in_tvalid && in_tready;

  assign line_ext = 64'(line_cnt_r);

  always_comb begin
    item.ch    = in_tdata;
    item.kind  = res.kind;
    item.start = res.start;
    item.line  = line_ext[LINE_OUT_W-1:0];
    line_cnt_nxt = line_cnt_r;
    if (res.line_inc && line_cnt_r != LINE_MAX) begin
      line_cnt_nxt = line_cnt_r + line_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '{mode: MODE_IDLE, esc: 1'b0, hash: 1'b0};
      line_cnt_r <= line_cnt_t'(1);
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      if (accept) begin
        st_r       <= st_nxt;
        line_cnt_r <= line_cnt_nxt;
      end
      if (!out_v_r || out_tready) begin
        // Output register is free: drain the skid stage first.
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= item;
          out_v_r <= accept;
        end
      end else if (accept) begin
        skid_r   <= item;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.line, out_r.ch};
  assign out_tuser  = {out_r.start, out_r.kind};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output register is empty");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r) && !$past(out_tready))
    else $error("skid register filled without an output stall");

  a_escape_in_literal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc |-> (st_r.mode == MODE_STR || st_r.mode == MODE_CHR))
    else $error("escape pending outside a literal");

  a_hash_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hash |-> (st_r.mode == MODE_IDLE))
    else $error("hash pending while a token is open");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r != '0)
    else $error("line counter reached zero");
`endif

endmodule

// ----- verif/cptl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptl_checker
// Watches both streams of the token lexer. Every accepted source byte is run
// through a behavioural lexer and its result is queued. Every accepted result
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module cptl_checker
  import cptl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [7:0] char_out, [39:8] line_number
  input  logic [3:0]  out_tuser,  // [2:0] token_kind, [3] token_start
  output int          err_cnt,
  output int          open_cnt
);

  typedef struct packed {
    char_t                 ch;
    kind_t                 kind;
    logic                  start;
    logic [LINE_OUT_W-1:0] line;
  } lexeme_t;

  lexeme_t   lexeme_q[$];
  mode_t     mode_q;
  logic      esc_q;
  logic      hash_q;
  line_cnt_t line_q;
  int        errs;

  function automatic logic blank_byte(input char_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic digit_byte(input char_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic word_head(input char_t c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  // Classifies one byte and advances the lexer state.
  function automatic lexeme_t lex_byte(input char_t c);
    lexeme_t r;
    logic    held;
    logic    had_hash;
    char_t   closer;
    r.ch     = c;
    r.kind   = KIND_PUNCT;
    r.start  = 1'b0;
    r.line   = LINE_OUT_W'(line_q);
    held     = 1'b1;
    had_hash = hash_q;
    hash_q   = 1'b0;
    if (mode_q == MODE_STR || mode_q == MODE_CHR) begin
      r.kind = (mode_q == MODE_STR) ? KIND_STR : KIND_CHR;
      closer = (mode_q == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
      if (esc_q) begin
        esc_q = 1'b0;
      end else if (c == CH_BSLASH) begin
        esc_q = 1'b1;
      end else if (c == closer) begin
        mode_q = MODE_IDLE;
      end
    end else if (mode_q == MODE_WS && blank_byte(c)) begin
      r.kind = KIND_WS;
    end else if (mode_q == MODE_IDENT && (word_head(c) || digit_byte(c))) begin
      r.kind = KIND_IDENT;
    end else if (mode_q == MODE_NUM && digit_byte(c)) begin
      r.kind = KIND_NUM;
    end else if (had_hash && c == CH_HASH) begin
      // Second half of a token-pasting pair; it cannot pair again.
      r.kind = KIND_PUNCT;
      mode_q = MODE_IDLE;
    end else begin
      held = 1'b0;
    end

    if (!held) begin
      r.start = 1'b1;
      esc_q   = 1'b0;
      if (c == CH_NL) begin
        r.kind = KIND_NL;
        mode_q = MODE_IDLE;
        if (line_q != {LINE_BITS{1'b1}}) line_q = line_q + 1'b1;
      end else if (blank_byte(c)) begin
        r.kind = KIND_WS;
        mode_q = MODE_WS;
      end else if (word_head(c)) begin
        r.kind = KIND_IDENT;
        mode_q = MODE_IDENT;
      end else if (digit_byte(c)) begin
        r.kind = KIND_NUM;
        mode_q = MODE_NUM;
      end else if (c == CH_DQUOTE) begin
        r.kind = KIND_STR;
        mode_q = MODE_STR;
      end else if (c == CH_SQUOTE) begin
        r.kind = KIND_CHR;
        mode_q = MODE_CHR;
      end else begin
        r.kind = KIND_PUNCT;
        mode_q = MODE_IDLE;
        hash_q = (c == CH_HASH);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lexeme_t got;
    lexeme_t want;
    if (!rst_n) begin
      mode_q = MODE_IDLE;
      esc_q  = 1'b0;
      hash_q = 1'b0;
      line_q = line_cnt_t'(1);
      errs   = 0;
      lexeme_q.delete();
    end else begin
      // A result can never belong to a byte accepted at the same edge, so
      // results are matched before the new request is queued.
      if (out_tvalid && out_tready) begin
        got.ch    = out_tdata[7:0];
        got.line  = out_tdata[8 +: LINE_OUT_W];
        got.kind  = out_tuser[2:0];
        got.start = out_tuser[3];
        if (lexeme_q.size() == 0) begin
          errs++;
          $display("%0t: expected no result, got ch=%h kind=%0d start=%0b line=%0d",
                   $time, got.ch, got.kind, got.start, got.line);
        end else begin
          want = lexeme_q.pop_front();
          if (got != want) begin
            errs++;
            $display("%0t: expected ch=%h kind=%0d start=%0b line=%0d,",
                     $time, want.ch, want.kind, want.start, want.line,
                     " got ch=%h kind=%0d start=%0b line=%0d",
                     got.ch, got.kind, got.start, got.line);
          end
        end
      end
      if (in_tvalid && in_tready) lexeme_q.push_back(lex_byte(in_tdata));
    end
    open_cnt <= lexeme_q.size();
    err_cnt  <= errs;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the token lexer a short hand-written stretch of C-like text covering
// every token class and the awkward corners, then a long stream of random
// tokens mixed with stray bytes, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top
  import cptl_pkg::*;
();

  localparam int  TEXT_BYTES  = 1500;
  localparam int  HOLD_CYCLES = 120;
  localparam int  BLOCK_BYTES = 100;
  localparam int  LIMIT       = 300000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;

  int    err_cnt;
  int    open_cnt;
  int    sent;
  int    cycles;
  bit    sender_idle;
  bit    receiver_idle;
  bit    hold_req;
  char_t text_q[$];

  c_preprocessor_token_lexer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cptl_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .err_cnt    (err_cnt),
    .open_cnt   (open_cnt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input char_t b);
    int gap;
    gap = sender_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Stops offering and waits until every queued result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_cnt != 0);
  endtask

  function automatic char_t literal_body_byte();
    char_t c;
    c = char_t'($urandom_range(8'h20, 8'h7E));
    if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) c = 8'h78;
    return c;
  endfunction

  // Appends one random token, mostly well formed, to the text queue.
  task automatic make_token();
    int    pick;
    int    n;
    int    r;
    char_t quote;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2, 3: begin
        r = $urandom_range(0, 52);
        text_q.push_back(r == 52 ? CH_UNDER :
                         r < 26  ? char_t'(8'h41 + r) : char_t'(8'h61 + r - 26));
        n = $urandom_range(0, 6);
        repeat (n) begin
          r = $urandom_range(0, 62);
          text_q.push_back(r == 62 ? CH_UNDER :
                           r < 10  ? char_t'(8'h30 + r) :
                           r < 36  ? char_t'(8'h41 + r - 10) : char_t'(8'h61 + r - 36));
        end
      end
      4, 5: begin
        n = $urandom_range(1, 5);
        repeat (n) text_q.push_back(char_t'($urandom_range(8'h30, 8'h39)));
      end
      6, 7, 8: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0:       text_q.push_back(CH_SPACE);
            1:       text_q.push_back(CH_TAB);
            2:       text_q.push_back(CH_CR);
            3:       text_q.push_back(CH_FF);
            default: text_q.push_back(CH_VT);
          endcase
        end
      end
      9, 10: text_q.push_back(CH_NL);
      11, 12, 13: begin
        quote = (pick == 13) ? CH_SQUOTE : CH_DQUOTE;
        text_q.push_back(quote);
        n = $urandom_range(0, 6);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r < 2) begin
            // Escape pair; the escaped byte may be a quote or a newline.
            text_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 3))
              0:       text_q.push_back(quote);
              1:       text_q.push_back(CH_NL);
              2:       text_q.push_back(CH_BSLASH);
              default: text_q.push_back(char_t'($urandom_range(1, 255)));
            endcase
          end else if (r == 2) begin
            text_q.push_back(char_t'($urandom_range(1, 255)));
          end else if (r == 3) begin
            text_q.push_back(CH_NL);
          end else begin
            text_q.push_back(literal_body_byte());
          end
        end
        // Now and then the literal is left open.
        if ($urandom_range(0, 9) != 0) text_q.push_back(quote);
      end
      14, 15: begin
        n = $urandom_range(1, 5);
        repeat (n) text_q.push_back(CH_HASH);
      end
      16, 17: begin
        case ($urandom_range(0, 7))
          0:       text_q.push_back(8'h28);
          1:       text_q.push_back(8'h29);
          2:       text_q.push_back(8'h2B);
          3:       text_q.push_back(8'h3B);
          4:       text_q.push_back(8'h7B);
          5:       text_q.push_back(8'h7D);
          6:       text_q.push_back(CH_BSLASH);
          default: text_q.push_back(char_t'($urandom_range(8'h80, 8'hFF)));
        endcase
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(char_t'($urandom_range(1, 255)));
      end
    endcase
  endtask

  // Result side: a random stall per result, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = receiver_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    char_t directed[] = '{
      8'h01, 8'hFF, CH_UNDER, 8'h5A, 8'h39, CH_SPACE, CH_TAB, CH_VT,
      8'h37, 8'h30, CH_NL,
      // A string holding an escaped quote and a raw newline.
      CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_NL, CH_DQUOTE,
      CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE,
      // Four hashes lex as two pasting pairs.
      CH_HASH, CH_HASH, CH_HASH, CH_HASH,
      CH_CR, CH_FF, CH_NL
    };
    int blk;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_req      = 1'b0;
    sent          = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    drain();

    blk = 0;
    while (sent < TEXT_BYTES) begin
      if (sent >= BLOCK_BYTES * (blk + 1) + directed.size()) begin
        blk++;
        if (blk == 2) begin
          // Keep offering while the result side is held off, so the output
          // stages fill and the input stalls.
          sender_idle = 1'b0;
          hold_req    = 1'b1;
        end else begin
          if (blk == 5) drain();
          sender_idle   = $urandom_range(0, 2) != 0;
          receiver_idle = $urandom_range(0, 2) != 0;
        end
      end
      if (text_q.size() == 0) make_token();
      send_byte(text_q.pop_front());
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (open_cnt != 0);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cptl_pkg.sv
rtl/cptl_classify.sv
rtl/c_preprocessor_token_lexer.sv
verif/cptl_checker.sv
verif/tb_top.sv
